// File: src/assert_macros.svh
// Assertion macros used by the checker file rucv_checker.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under clock and reset
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication under clock and reset
`define ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: src/rucv_pkg.sv
// Package for the rectangle union cover test: payload types, codes, clip function.
// No dependencies.
package rucv_pkg;

   localparam int unsigned DEF_MAX_RECTS = 32;

   typedef enum logic [1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_APPEND = 2'd1,
      CMD_QUERY  = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } state_type;

   typedef struct packed {
      cmd_type            command;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic signed [15:0] size_w;
      logic signed [15:0] size_h;
   } req_type;

   typedef struct packed {
      logic covered;
      logic overflowed;
   } rsp_type;

   // Table entry, x in the low bits
   typedef struct packed {
      logic signed [15:0] h;
      logic signed [15:0] w;
      logic signed [15:0] y;
      logic signed [15:0] x;
   } box_type;

   // Entry clipped to the query, half-open [x0,x1) x [y0,y1)
   typedef struct packed {
      logic               valid;
      logic signed [16:0] x0;
      logic signed [16:0] y0;
      logic signed [16:0] x1;
      logic signed [16:0] y1;
   } clip_type;

   // Test point travelling down the cell row
   typedef struct packed {
      logic               valid;
      logic               hit;
      logic signed [16:0] x;
      logic signed [16:0] y;
   } point_type;

   function automatic clip_type clip_box(box_type q, box_type e);
      logic signed [16:0] qx, qy, qr, qb, ex, ey, er, eb;
      clip_type c;
      qx = 17'(q.x);
      qy = 17'(q.y);
      ex = 17'(e.x);
      ey = 17'(e.y);
      qr = qx + 17'(q.w);
      qb = qy + 17'(q.h);
      er = ex + 17'(e.w);
      eb = ey + 17'(e.h);
      c.x0 = (qx > ex) ? qx : ex;
      c.y0 = (qy > ey) ? qy : ey;
      c.x1 = (qr < er) ? qr : er;
      c.y1 = (qb < eb) ? qb : eb;
      c.valid = (c.x1 > c.x0) && (c.y1 > c.y0);
      return c;
   endfunction

endpackage

// File: src/rucv_table.sv
// Rectangle table memory: one write port, two registered read ports.
// Depends on rucv_pkg.
module rucv_table import rucv_pkg::*; #(
   parameter int unsigned MAX_RECTS = DEF_MAX_RECTS,
   parameter int unsigned AW = 5
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  box_type       wr_data,
   input  logic [AW-1:0] rd_addr_a,
   input  logic [AW-1:0] rd_addr_b,
   output box_type       rd_data_a,
   output box_type       rd_data_b
);

   box_type mem [MAX_RECTS];
   box_type rd_a_ff, rd_b_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read ports
   always_ff @(posedge clock) begin
      rd_a_ff <= mem[rd_addr_a];
      rd_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// File: src/rucv_cell.sv
// One cell of the row: holds one clip, tests each passing point against it.
// Depends on rucv_pkg.
module rucv_cell import rucv_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      shift_en,
   input  clip_type  clip_in,
   output clip_type  clip_out,
   input  point_type pt_in,
   output point_type pt_out
);

   clip_type  clip_ff;
   point_type pt_ff, pt_in_next;
   logic      hit_here;

   // point inside own clip
   always_comb begin
      hit_here = clip_ff.valid &&
                 (pt_in.x >= clip_ff.x0) && (pt_in.x < clip_ff.x1) &&
                 (pt_in.y >= clip_ff.y0) && (pt_in.y < clip_ff.y1);
      pt_in_next     = pt_in;
      pt_in_next.hit = pt_in.hit | hit_here;
   end

   // clip shifts during load, point moves on every cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         clip_ff.valid <= 1'b0;
         pt_ff.valid   <= 1'b0;
      end else begin
         if (shift_en) begin
            clip_ff <= clip_in;
         end
         pt_ff <= pt_in_next;
      end
   end

   assign clip_out = clip_ff;
   assign pt_out   = pt_ff;

endmodule

// File: src/rect_union_cover_test_top.sv
// Channel | ports                         | carries
// req     | req_valid, req_stall, req_data | command and rectangle (req_type)
// rsp     | rsp_valid, rsp_stall, rsp_data | covered, overflowed (rsp_type)
//
// Clear and append finish without a busy state. A query that is trivially
// uncovered goes straight to the done state. Otherwise a query makes a load
// pass into the cell row, then sends one test point per cycle down the row,
// set by the candidate point scan, then drains the row. Reset is synchronous and
// empties the table. A stalled result holds; the next item may be taken meanwhile.
// Depends on rucv_pkg, rucv_table, rucv_cell.
module rect_union_cover_test_top import rucv_pkg::*; #(
   parameter int unsigned MAX_RECTS = DEF_MAX_RECTS
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int unsigned AW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
   localparam int unsigned CW = $clog2(MAX_RECTS + 1);
   localparam int unsigned NW = $clog2(MAX_RECTS + 3);

   state_type       state_ff, state_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            ovf_ff, ovf_in;
   box_type         qry_ff, qry_in;
   logic            qovf_ff, qovf_in;
   logic            any_ff, any_in;
   logic            miss_ff, miss_in;
   logic [NW-1:0]   cnt_ff, cnt_in;
   logic [CW-1:0]   xi_ff, xi_in, yi_ff, yi_in;
   logic            ld_pend_ff, ld_val_ff;
   logic            sc_pend_ff, sc_x0_ff, sc_xv_ff, sc_y0_ff, sc_yv_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_data_ff, rsp_data_in;

   logic            accept, trivial, wr_en, out_free;
   logic [CW-1:0]   xm1, ym1;
   logic [AW-1:0]   rd_addr_a, rd_addr_b;
   box_type         rd_data_a, rd_data_b, wr_data;
   clip_type        ca, cb, clip_feed;
   point_type       pt_feed;
   logic signed [16:0] qx, qy, qr, qb;

   clip_type  clip_link [MAX_RECTS+1];
   point_type pt_link   [MAX_RECTS+1];

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign trivial  = ovf_ff || (req_data.size_w <= 16'sd0) ||
                     (req_data.size_h <= 16'sd0) || (count_ff == '0);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_data.command == CMD_QUERY) begin
               state_in = trivial ? ST_DONE : ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (cnt_ff == NW'(MAX_RECTS - 1)) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (xi_ff == CW'(MAX_RECTS) && yi_ff == CW'(MAX_RECTS)) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (cnt_ff == NW'(MAX_RECTS + 2)) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      xm1       = xi_ff - 1'b1;
      ym1       = yi_ff - 1'b1;
      req_stall = (state_ff != ST_IDLE);
      rd_addr_a = (state_ff == ST_LOAD) ? cnt_ff[AW-1:0] : xm1[AW-1:0];
      rd_addr_b = ym1[AW-1:0];
      wr_en     = (state_ff == ST_IDLE) && accept && (req_data.command == CMD_APPEND) &&
                  (count_ff < CW'(MAX_RECTS));
   end

   assign wr_data = '{h: req_data.size_h, w: req_data.size_w,
                      y: req_data.pos_y,  x: req_data.pos_x};

   // clip and candidate point from the table read data
   always_comb begin
      qx = 17'(qry_ff.x);
      qy = 17'(qry_ff.y);
      qr = qx + 17'(qry_ff.w);
      qb = qy + 17'(qry_ff.h);
      ca = clip_box(qry_ff, rd_data_a);
      cb = clip_box(qry_ff, rd_data_b);
      clip_feed       = ca;
      clip_feed.valid = ca.valid && ld_val_ff;
      pt_feed.hit   = 1'b0;
      pt_feed.x     = sc_x0_ff ? qx : ca.x1;
      pt_feed.y     = sc_y0_ff ? qy : cb.y1;
      pt_feed.valid = sc_pend_ff &&
                      (sc_x0_ff || (sc_xv_ff && ca.valid && ca.x1 < qr)) &&
                      (sc_y0_ff || (sc_yv_ff && cb.valid && cb.y1 < qb));
   end

   // table bookkeeping, query registers and counters
   always_comb begin
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      qry_in       = qry_ff;
      qovf_in      = qovf_ff;
      any_in       = any_ff | (ld_pend_ff && clip_feed.valid);
      miss_in      = miss_ff | (pt_link[MAX_RECTS].valid && !pt_link[MAX_RECTS].hit);
      cnt_in       = cnt_ff;
      xi_in        = xi_ff;
      yi_in        = yi_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (state_ff == ST_IDLE && accept) begin
         case (req_data.command)
            CMD_CLEAR: begin
               count_in = '0;
               ovf_in   = 1'b0;
            end
            CMD_APPEND: begin
               if (wr_en) count_in = count_ff + 1'b1;
               else       ovf_in   = 1'b1;
            end
            CMD_QUERY: begin
               qry_in  = wr_data;
               qovf_in = ovf_ff;
               any_in  = 1'b0;
               miss_in = 1'b0;
               cnt_in  = '0;
               xi_in   = '0;
               yi_in   = '0;
            end
            default: ;
         endcase
      end
      if (state_ff == ST_LOAD || state_ff == ST_DRAIN) cnt_in = cnt_ff + 1'b1;
      if (state_ff == ST_SCAN) begin
         cnt_in = '0;
         if (yi_ff == CW'(MAX_RECTS)) begin
            yi_in = '0;
            xi_in = xi_ff + 1'b1;
         end else begin
            yi_in = yi_ff + 1'b1;
         end
      end
      if (state_ff == ST_DONE && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '{covered: any_ff && !miss_ff, overflowed: qovf_ff};
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         ld_pend_ff   <= 1'b0;
         sc_pend_ff   <= 1'b0;
         any_ff       <= 1'b0;
         miss_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         ld_pend_ff   <= (state_ff == ST_LOAD);
         sc_pend_ff   <= (state_ff == ST_SCAN);
         any_ff       <= any_in;
         miss_ff      <= miss_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and index registers
   always_ff @(posedge clock) begin
      qry_ff      <= qry_in;
      qovf_ff     <= qovf_in;
      cnt_ff      <= cnt_in;
      xi_ff       <= xi_in;
      yi_ff       <= yi_in;
      rsp_data_ff <= rsp_data_in;
      ld_val_ff   <= (NW'(cnt_ff) < NW'(count_ff));
      sc_x0_ff    <= (xi_ff == '0);
      sc_xv_ff    <= (xi_ff <= count_ff);
      sc_y0_ff    <= (yi_ff == '0);
      sc_yv_ff    <= (yi_ff <= count_ff);
   end

   rucv_table #(.MAX_RECTS(MAX_RECTS), .AW(AW)) u_table (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (count_ff[AW-1:0]),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   // row of cells
   assign clip_link[0] = clip_feed;
   assign pt_link[0]   = pt_feed;

   for (genvar k = 0; k < MAX_RECTS; k++) begin : g_cell
      rucv_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (ld_pend_ff),
         .clip_in  (clip_link[k]),
         .clip_out (clip_link[k+1]),
         .pt_in    (pt_link[k]),
         .pt_out   (pt_link[k+1])
      );
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: src/rucv_checker.sv
// Port-level checks for the rectangle union cover test, bound to the top level.
// Depends on rucv_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rucv_checker import rucv_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // a stalled result holds
   `ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // a query keeps the block busy in the next cycle
   `ASSERT_NXT(a_query_busy, clock, reset,
      req_valid && !req_stall && req_data.command == CMD_QUERY, req_stall)

   // clear and append do not make the block busy
   `ASSERT_NXT(a_table_op_quick, clock, reset,
      req_valid && !req_stall && req_data.command != CMD_QUERY, !req_stall)

endmodule

bind rect_union_cover_test_top rucv_checker u_rucv_checker (.*);
